[design/hcbd_pkg.sv]
`default_nettype none
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DROP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_ZERO,
        KIND_ERROR,
        KIND_ENDED
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       has_end;
        t_kind      end_kind;
    } t_op;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_LF = 8'd10;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = 5'(c - 8'd48);
        end else if (c >= 8'd97 && c <= 8'd102) begin
            v = 5'(c - 8'd87);
        end else if (c >= 8'd65 && c <= 8'd70) begin
            v = 5'(c - 8'd55);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[design/http_chunked_body_decoder_unit.sv]
// Chunked HTTP body decoder. Raw body bytes enter on the slave stream one word
// per cycle while the queue is not full; data bytes of each chunk leave on the
// master stream with tuser 0, and a body closes with one word of tlast high
// whose tuser gives the reason: 1 zero-size chunk, 2 format error, 3 input
// ended. After a stop the rest of the body is dropped up to the input word
// marked tlast. The input side takes one word every cycle; tready drops only
// when the queue is full. The output side gives one word a cycle while the
// queue is not empty and tready is high, but a final data byte marked tlast
// yields two output words. A four-entry queue between the parser and the
// output sequencer absorbs that and any downstream stall. SIZE_DIGITS sets the
// longest size line accepted and the byte counter width (4 bits per digit).
`default_nettype none
module http_chunked_body_decoder_unit #(
    parameter int SIZE_DIGITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic [1:0]       o_m_tuser,   // [1:0] out_kind
    output logic             o_m_tlast
);
    logic          push, pop, full, empty;
    hcbd_pkg::t_op push_op, head_op;

    hcbd_front #(
        .SIZE_DIGITS(SIZE_DIGITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_op    (push_op)
    );

    hcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_empty (empty)
    );

    hcbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_op),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );
endmodule
`default_nettype wire

[design/hcbd_front.sv]
`default_nettype none
module hcbd_front #(
    parameter int SIZE_DIGITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic        i_full,
    output logic             o_push,
    output hcbd_pkg::t_op    o_op
);
    localparam int BW  = 4 * SIZE_DIGITS;
    localparam int DCW = $clog2(SIZE_DIGITS + 1);

    hcbd_pkg::t_phase r_phase, n_phase;
    logic [BW-1:0]    r_left, n_left;
    logic [DCW-1:0]   r_cnt, n_cnt;

    logic             accept;
    logic             stop;
    hcbd_pkg::t_kind  stop_kind;
    logic [4:0]       hv;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign hv      = hcbd_pkg::hex_value(i_byte);

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_cnt     = r_cnt;
        stop      = 1'b0;
        stop_kind = hcbd_pkg::KIND_ERROR;
        o_op      = '0;
        o_op.data = i_byte;
        unique case (r_phase)
            hcbd_pkg::PH_SIZE: begin
                if (i_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end else if (!hv[4] && r_cnt < DCW'(SIZE_DIGITS)) begin
                    n_left = BW'({r_left, hv[3:0]});
                    n_cnt  = r_cnt + DCW'(1);
                end else begin
                    stop = 1'b1;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                if (i_byte != hcbd_pkg::BYTE_LF) begin
                    stop = 1'b1;
                end else if (r_left == '0) begin
                    stop      = 1'b1;
                    stop_kind = hcbd_pkg::KIND_ZERO;
                end else begin
                    n_phase = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA: begin
                o_op.has_data = 1'b1;
                n_left        = r_left - BW'(1);
                if (r_left == BW'(1)) begin
                    n_phase = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (i_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    stop = 1'b1;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (i_byte == hcbd_pkg::BYTE_LF) begin
                    n_phase = hcbd_pkg::PH_SIZE;
                    n_left  = '0;
                    n_cnt   = '0;
                end else begin
                    stop = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (r_phase == hcbd_pkg::PH_DROP) begin
            if (i_last) begin
                n_phase = hcbd_pkg::PH_SIZE;
                n_left  = '0;
                n_cnt   = '0;
            end
        end else if (stop) begin
            o_op.has_end  = 1'b1;
            o_op.end_kind = stop_kind;
            n_phase       = i_last ? hcbd_pkg::PH_SIZE : hcbd_pkg::PH_DROP;
            n_left        = '0;
            n_cnt         = '0;
        end else if (i_last) begin
            o_op.has_end  = 1'b1;
            o_op.end_kind = hcbd_pkg::KIND_ENDED;
            n_phase       = hcbd_pkg::PH_SIZE;
            n_left        = '0;
            n_cnt         = '0;
        end
    end

    assign o_push = accept && (o_op.has_data || o_op.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hcbd_pkg::PH_SIZE;
            r_left  <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

[design/hcbd_queue.sv]
`default_nettype none
module hcbd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hcbd_pkg::t_op  i_op,
    output logic                o_full,
    input  wire logic           i_pop,
    output hcbd_pkg::t_op       o_head,
    output logic                o_empty
);
    hcbd_pkg::t_op                r_mem [hcbd_pkg::QUEUE_DEPTH];
    logic [hcbd_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [hcbd_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = r_count == (hcbd_pkg::QUEUE_AW+1)'(hcbd_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + hcbd_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + hcbd_pkg::QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (hcbd_pkg::QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (hcbd_pkg::QUEUE_AW+1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

[design/hcbd_back.sv]
`default_nettype none
module hcbd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hcbd_pkg::t_op  i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_data,
    output logic [1:0]          o_user,
    output logic                o_last
);
    logic r_second;
    logic show_data;
    logic split;

    assign show_data = i_head.has_data && !r_second;
    assign split     = show_data && i_head.has_end;

    assign o_valid = !i_empty;
    assign o_data  = show_data ? i_head.data : 8'd0;
    assign o_user  = show_data ? 2'(hcbd_pkg::KIND_DATA) : 2'(i_head.end_kind);
    assign o_last  = !show_data;
    assign o_pop   = o_valid && i_ready && !split;

    // data word goes first, end word on the next handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_second <= split;
        end
    end
endmodule
`default_nettype wire
